/* rtl/mavg_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared constants and types for the moving average filter blocks.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WIDTH_REG_BITS  = 9;

    localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 9'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/moving_average_filter_unit.sv */
// ----------------------------------------------------------------------------
// Moving average filter unit
// Streaming boxcar average over a configurable window of recent samples.
// ----------------------------------------------------------------------------
// A request that completes the window gives its average through the divider,
// which works out one quotient bit per cycle. The back end takes no new sample
// until the current average is in the output register; the front-end queue
// holds up to two samples meanwhile.
// Reset clears the window, the running sum and the queue; the width becomes 4.
module moving_average_filter_unit #(
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
    parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [TDATA_BITS-1:0]               s_axis_tdata,  // sample
    input  logic                                s_axis_tuser,  // first_of_set
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [TDATA_BITS-1:0]               m_axis_tdata,  // average
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mavg_pkg::WIDTH_REG_BITS-1:0] cfg_data       // width
);
    import mavg_pkg::*;

    logic                          q_valid;
    logic                          q_ready;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          q_first;
    logic signed [SAMPLE_BITS-1:0] average;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = TDATA_BITS'(unsigned'(average));

    mavg_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .in_first   (s_axis_tuser),
        .out_valid  (q_valid),
        .out_ready  (q_ready),
        .out_sample (q_sample),
        .out_first  (q_first)
    );

    mavg_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_sample   (q_sample),
        .in_first    (q_first),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_width   (cfg_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_average (average)
    );

endmodule

/* rtl/mavg_front.sv */
// ----------------------------------------------------------------------------
// Moving average filter front end
// Accepts sample requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mavg_front #(
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_first,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_first
);
    import mavg_pkg::*;

    logic signed [SAMPLE_BITS-1:0] sample_q_reg [2];
    logic                          first_q_reg  [2];
    logic                          wr_ptr_reg;
    logic                          wr_ptr_next;
    logic                          rd_ptr_reg;
    logic                          rd_ptr_next;
    logic [1:0]                    count_reg;
    logic [1:0]                    count_next;
    logic                          push;
    logic                          pop;

    assign in_ready   = (count_reg != 2'd2);
    assign out_valid  = (count_reg != 2'd0);
    assign out_sample = sample_q_reg[rd_ptr_reg];
    assign out_first  = first_q_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sample_q_reg[wr_ptr_reg] <= in_sample;
            first_q_reg[wr_ptr_reg]  <= in_first;
        end
    end

endmodule

/* rtl/mavg_divider.sv */
// ----------------------------------------------------------------------------
// Moving average filter divider
// Iterative signed by unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module mavg_divider #(
    parameter int SUM_BITS = 24,
    parameter int DIV_BITS = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       take,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]        divisor,
    output logic signed [SUM_BITS-1:0] quotient,
    output mavg_pkg::div_status_t      status
);
    import mavg_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   divisor_reg;
    logic [SUM_BITS-1:0]   quo_reg;
    logic [DIV_BITS:0]     shifted;
    logic                  fits;
    logic [DIV_BITS:0]     diff;
    logic [SUM_BITS-1:0]   magnitude;

    assign shifted   = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits      = (shifted >= {1'b0, divisor_reg});
    assign diff      = shifted - {1'b0, divisor_reg};
    assign magnitude = dividend[SUM_BITS-1] ? (~unsigned'(dividend) + 1'b1)
                                            : unsigned'(dividend);
    assign quotient  = neg_reg ? signed'(~quo_reg + 1'b1) : signed'(quo_reg);
    assign status    = '{busy: busy_reg, done: done_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_BITS'(SUM_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg     <= dividend[SUM_BITS-1];
            quo_reg     <= magnitude;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
        end
    end

endmodule

/* rtl/mavg_back.sv */
// ----------------------------------------------------------------------------
// Moving average filter back end
// Keeps the sample ring and running sum, and produces each window average.
// ----------------------------------------------------------------------------
module mavg_back #(
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         in_sample,
    input  logic                                  in_first,
    input  logic                                  cfg_write,
    input  logic [mavg_pkg::WIDTH_REG_BITS-1:0]   cfg_width,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         out_average
);
    import mavg_pkg::*;

    localparam int WB       = $clog2(MAX_WINDOW + 1);
    localparam int RB       = $clog2(MAX_WINDOW);
    localparam int CB       = (WB > WIDTH_REG_BITS) ? WB : WIDTH_REG_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [WIDTH_REG_BITS-1:0]     width_reg;
    logic [WIDTH_REG_BITS-1:0]     width_next;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic [WB-1:0]                 fill_reg;
    logic [WB-1:0]                 fill_next;
    logic [RB-1:0]                 slot_reg;
    logic [RB-1:0]                 slot_next;
    logic signed [SAMPLE_BITS-1:0] cur_sample_reg;
    logic signed [SAMPLE_BITS-1:0] cur_sample_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_next;

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] ring_rd_reg;

    logic [CB-1:0]                 width_ext;
    logic [WB-1:0]                 eff_w;
    logic                          pop;
    logic [RB-1:0]                 slot_eff;
    logic                          full;
    logic [SUM_BITS-1:0]           old_term;
    logic signed [SUM_BITS-1:0]    sum_acc;
    logic                          result;
    logic [WB-1:0]                 slot_inc;
    logic                          div_start;
    logic                          div_take;
    logic signed [SUM_BITS-1:0]    quotient;
    div_status_t                   div_status;

    assign width_ext = CB'(width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            eff_w = WB'(1);
        end
        else if (width_ext > CB'(MAX_WINDOW))
        begin
            eff_w = WB'(MAX_WINDOW);
        end
        else
        begin
            eff_w = width_ext[WB-1:0];
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign pop      = in_valid && in_ready;

    always_comb
    begin
        if (in_first || (WB'(slot_reg) >= eff_w))
        begin
            slot_eff = '0;
        end
        else
        begin
            slot_eff = slot_reg;
        end
    end

    assign full      = (fill_reg >= eff_w);
    assign old_term  = full ? SUM_BITS'(ring_rd_reg) : '0;
    assign sum_acc   = sum_reg - signed'(old_term) + SUM_BITS'(cur_sample_reg);
    assign result    = full || ((fill_reg + 1'b1) == eff_w);
    assign slot_inc  = WB'(slot_reg) + 1'b1;
    assign div_start = (state_reg == ST_ACC) && result;
    assign div_take  = (state_reg == ST_DIV) && div_status.done
                       && (!out_valid_reg || out_ready);

    assign out_valid   = out_valid_reg;
    assign out_average = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        cur_sample_next = cur_sample_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_sample_next = in_sample;
                    slot_next       = slot_eff;
                    if (in_first)
                    begin
                        sum_next  = '0;
                        fill_next = '0;
                    end
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                sum_next  = sum_acc;
                fill_next = full ? eff_w : (fill_reg + 1'b1);
                slot_next = (slot_inc >= eff_w) ? '0 : slot_inc[RB-1:0];
                state_next = result ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_take)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = quotient[SAMPLE_BITS-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            width_next = cfg_width;
            sum_next   = '0;
            fill_next  = '0;
            slot_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= WIDTH_RESET;
            sum_reg        <= '0;
            fill_reg       <= '0;
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cur_sample_reg <= '0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            slot_reg       <= slot_next;
            out_valid_reg  <= out_valid_next;
            cur_sample_reg <= cur_sample_next;
            out_data_reg   <= out_data_next;
        end
    end

    // The outgoing sample is read while the request is taken and replaced in the next cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC)
        begin
            ring_mem[slot_reg] <= cur_sample_reg;
        end
        if (pop)
        begin
            ring_rd_reg <= ring_mem[slot_eff];
        end
    end

    mavg_divider #(
        .SUM_BITS (SUM_BITS),
        .DIV_BITS (WB)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .take     (div_take),
        .dividend (sum_acc),
        .divisor  (eff_w),
        .quotient (quotient),
        .status   (div_status)
    );

endmodule

/* rtl/mavg_checker.sv */
// ----------------------------------------------------------------------------
// Moving average filter checker
// Port-level assertions for the moving average filter unit, bound to the top.
// ----------------------------------------------------------------------------
module mavg_checker #(
    parameter int TDATA_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [TDATA_BITS-1:0] m_axis_tdata
);

    logic take;

    assign take = m_axis_tvalid && m_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result request changed or was dropped.");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("Result request present straight after reset.");

    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("Input queue became full without an accepted request.");

    a_div_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        take ##1 take |=> !take)
        else $error("Averages delivered faster than the divider can produce them.");

endmodule

bind moving_average_filter_unit mavg_checker #(
    .TDATA_BITS (TDATA_BITS)
) u_mavg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Moving average filter unit testbench
// Streams signed samples through the boxcar filter under varying window
// widths and handshake pressure, and compares every average with a
// behavioural model of the window kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_top;

    import mavg_pkg::*;

    localparam int  SMP_BITS      = SAMPLE_BITS_DEF;
    localparam int  WIN_MAX       = MAX_WINDOW_DEF;
    localparam int  SETTLE_CYCLES = 40;
    localparam time RUN_LIMIT     = 10_000_000;

    typedef logic signed [SMP_BITS-1:0] sample_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [SMP_BITS-1:0]       s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [SMP_BITS-1:0]       m_axis_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [WIDTH_REG_BITS-1:0] cfg_data = '0;

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;

    // Model of the filter window.
    sample_t                   sample_window [WIN_MAX];
    longint                    window_sum;
    int unsigned               held_count;
    int unsigned               next_slot;
    logic [WIDTH_REG_BITS-1:0] width_setting;

    sample_t     expected_averages[$];
    int unsigned error_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned averages_seen  = 0;
    int unsigned width_writes   = 0;

    moving_average_filter_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_window();
        window_sum = 0;
        held_count = 0;
        next_slot  = 0;
    endfunction

    function automatic void predict_average(sample_t smp, bit first);
        int unsigned width;
        longint      quotient;
        width = 32'(width_setting);
        if (width == 0)
            width = 1;
        if (width > WIN_MAX)
            width = WIN_MAX;
        if (first)
            clear_window();
        if (next_slot >= width)
            next_slot = 0;
        if (held_count >= width)
        begin
            window_sum -= longint'(sample_window[next_slot]);
            held_count = width;
        end
        sample_window[next_slot] = smp;
        window_sum += longint'(smp);
        next_slot++;
        if (next_slot >= width)
            next_slot = 0;
        if (held_count < width)
            held_count++;
        if (held_count >= width)
        begin
            quotient = window_sum / longint'(width);
            expected_averages.insert(expected_averages.size(),
                                     sample_t'(quotient[SMP_BITS-1:0]));
        end
    endfunction

    function automatic sample_t pick_sample();
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(3))
                0:       return sample_t'(16'sh7fff);
                1:       return sample_t'(16'sh8000);
                2:       return sample_t'(0);
                default: return sample_t'(-1);
            endcase
        end
        return sample_t'($urandom);
    endfunction

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    task automatic send_sample(input sample_t smp, input bit first);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tuser  = first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_average(smp, first);
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_REG_BITS-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        width_setting = value;
        clear_window();
        width_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge clk)
        m_axis_tready = ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_averages.size() == 0)
            begin
                $error("average: unexpected result %0d", $signed(m_axis_tdata));
                error_count++;
            end
            else
            begin
                if (m_axis_tdata !== expected_averages[0])
                begin
                    $error("average mismatch: expected %0d, actual %0d",
                           expected_averages[0], $signed(m_axis_tdata));
                    error_count++;
                end
                void'(expected_averages.pop_front());
                averages_seen++;
            end
        end
    end

    task automatic test_directed();
        // Full-scale windows at the reset width of four.
        send_sample(16'sh7fff, 1'b1);
        repeat (3) send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
        repeat (3) send_sample(16'sh8000, 1'b0);
        // A small negative sum must truncate towards zero.
        send_sample(sample_t'(-1), 1'b1);
        repeat (3) send_sample(sample_t'(0), 1'b0);
        write_width(WIDTH_REG_BITS'(1));
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(sample_t'(-1), 1'b1);
        // A width of zero behaves as a width of one.
        write_width(WIDTH_REG_BITS'(0));
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(-7), 1'b0);
        // Widths above the ring size saturate, so no average appears yet.
        write_width('1);
        send_sample(sample_t'(123), 1'b1);
        send_sample(sample_t'(-456), 1'b0);
        // A new set part-way through a window discards the earlier samples.
        write_width(WIDTH_REG_BITS'(3));
        send_sample(sample_t'(10), 1'b1);
        send_sample(sample_t'(20), 1'b0);
        send_sample(sample_t'(7), 1'b1);
        send_sample(sample_t'(8), 1'b0);
        send_sample(sample_t'(9), 1'b0);
    endtask

    task automatic test_random_sets(input int unsigned quota);
        int unsigned sent;
        int unsigned width;
        int unsigned phase_items;
        int unsigned set_len;
        sent = 0;
        while (sent < quota)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: width = $urandom_range(1, 8);
                6, 7:             width = $urandom_range(9, 40);
                8:                width = $urandom_range(0, 1);
                default:          width = $urandom_range(2, 16);
            endcase
            write_width(WIDTH_REG_BITS'(width));
            if (width == 0)
                width = 1;
            phase_items = 0;
            while (phase_items < $urandom_range(20, 50))
            begin
                // Most sets fill the window and slide on; a few stop short.
                if ($urandom_range(9) == 0)
                    set_len = $urandom_range(1, width);
                else
                    set_len = width + $urandom_range(0, 2 * width + 4);
                for (int unsigned k = 0; k < set_len; k++)
                begin
                    send_sample(pick_sample(),
                                (k == 0) || ($urandom_range(19) == 0));
                    phase_items++;
                end
            end
            sent += phase_items;
        end
    endtask

    task automatic test_wide_window();
        // An oversized width saturates to the full ring at negative full scale.
        write_width('1);
        send_sample(16'sh8000, 1'b1);
        repeat (WIN_MAX) send_sample(16'sh8000, 1'b0);
        repeat (8) send_sample(pick_sample(), 1'b0);
    endtask

    initial
    begin
        width_setting = WIDTH_RESET;
        clear_window();
        foreach (sample_window[i])
            sample_window[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(20, 50);
        test_directed();
        test_random_sets(90);
        test_wide_window();
        set_idling(50, 20);
        test_random_sets(90);
        set_idling(0, 0);
        test_random_sets(90);
        drain();

        $display("Sent %0d sample requests over %0d window width writes.",
                 requests_sent, width_writes);
        $display("Checked %0d averages, %0d errors.", averages_seen, error_count);
        if (error_count == 0 && expected_averages.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Run limit reached with %0d averages outstanding.",
                 expected_averages.size());
        $display("tb_top failed");
        $finish;
    end

endmodule
